[design/cau_pkg.sv]
// Shared types and constants of the complex arithmetic unit.
package cau_pkg;

    localparam int DATA_BITS = 32;
    localparam int CMD_BITS  = 3;

    // Command codes carried in s_tuser
    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_NEG   = 3'd2,
        CMD_MUL   = 3'd3,
        CMD_DIV   = 3'd4,
        CMD_SCALE = 3'd5,
        CMD_EQ    = 3'd6,
        CMD_NE    = 3'd7
    } cmd_t;

    // One queued item as classified by the front end
    typedef struct packed {
        logic                 is_div;
        cmd_t                 cmd;
        logic [DATA_BITS-1:0] a_re;
        logic [DATA_BITS-1:0] a_im;
        logic [DATA_BITS-1:0] b_re;
        logic [DATA_BITS-1:0] b_im;
    } cau_item_t;

    // Divider status seen by the back end
    typedef struct packed {
        logic idle;
        logic done;
    } div_stat_t;

endpackage

[design/cau_front.sv]
// Front end: accepts items, classifies the command and queues them for the back end.
module cau_front
    import cau_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [4*DATA_BITS-1:0] s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [CMD_BITS-1:0]    s_tuser,   // command
    output logic                   q_valid,
    input  logic                   q_ready,
    output cau_item_t              q_item
);

    cau_item_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    cau_item_t  in_item;

    // classify the incoming item
    always_comb begin
        in_item.cmd    = cmd_t'(s_tuser);
        in_item.is_div = (cmd_t'(s_tuser) == CMD_DIV);
        in_item.a_re   = s_tdata[DATA_BITS-1:0];
        in_item.a_im   = s_tdata[2*DATA_BITS-1:DATA_BITS];
        in_item.b_re   = s_tdata[3*DATA_BITS-1:2*DATA_BITS];
        in_item.b_im   = s_tdata[4*DATA_BITS-1:3*DATA_BITS];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    // two-entry queue pointers
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[design/cau_div.sv]
// Shift-subtract divider for one result part, one quotient bit per cycle, with clamping.
module cau_div
    import cau_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start_i,
    input  logic             ack_i,
    input  logic             neg_i,
    input  logic [2*W-1:0]   mag_i,
    input  logic [2*W-1:0]   den_i,
    output div_stat_t        stat_o,
    output logic [W-1:0]     res_o,
    output logic             sat_o
);

    localparam int MW = 2 * W;
    localparam int NW = MW + F;
    localparam int RW = MW + 1;
    localparam int CW = $clog2(W + 2);
    localparam logic [W:0]   LIMQ = (W + 1)'(1) << (W - 1);
    localparam logic [W-1:0] MAXW = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0] MINW = {1'b1, {(W - 1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } div_state_t;

    div_state_t      state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [RW-1:0]   rem_reg, rem_next;
    logic [W:0]      lo_reg, lo_next;
    logic [W:0]      q_reg, q_next;
    logic [MW-1:0]   den_reg, den_next;
    logic            neg_reg, neg_next;
    logic            ovf_reg, ovf_next;
    logic [NW-1:0]   num, hi;
    logic [RW-1:0]   trial;
    logic            ge;
    logic [W:0]      neg_q;

    assign num   = NW'(mag_i) << F;
    assign hi    = num >> (W + 1);
    assign trial = {rem_reg[MW-1:0], lo_reg[W]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign neg_q = (W + 1)'(0) - q_reg;

    // sequencer and datapath
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        q_next     = q_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start_i) begin
                    state_next = ST_RUN;
                    cnt_next   = CW'(W + 1);
                    rem_next   = RW'(hi);
                    lo_next    = num[W:0];
                    q_next     = '0;
                    den_next   = den_i;
                    neg_next   = neg_i;
                    ovf_next   = (hi >= NW'(den_i));
                end
            end
            ST_RUN: begin
                rem_next = ge ? (trial - {1'b0, den_reg}) : trial;
                q_next   = {q_reg[W-1:0], ge};
                lo_next  = lo_reg << 1;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (ack_i) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
    end

    // clamp the quotient into the signed word range
    always_comb begin
        if (ovf_reg) begin
            sat_o = 1'b1;
            res_o = neg_reg ? MINW : MAXW;
        end else if (!neg_reg) begin
            sat_o = (q_reg >= LIMQ);
            res_o = sat_o ? MAXW : q_reg[W-1:0];
        end else begin
            sat_o = (q_reg > LIMQ);
            res_o = sat_o ? MINW : neg_q[W-1:0];
        end
    end

    assign stat_o.idle = (state_reg == ST_IDLE);
    assign stat_o.done = (state_reg == ST_DONE);

endmodule

[design/cau_back.sv]
// Back end: product stage, result stage, divider control and output register.
module cau_back
    import cau_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  cau_item_t              q_item,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [2*DATA_BITS-1:0] m_tdata,   // res_re, res_im
    output logic [2:0]             m_tuser    // compare_true, div_zero, saturated
);

    localparam int PW = 2 * W;
    localparam int MW = 2 * W;
    localparam int SW = 2 * W + 2;
    localparam logic signed [SW-1:0] SMAX = (SW'(1) <<< (W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);
    localparam logic [W-1:0] MAXW = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0] MINW = {1'b1, {(W - 1){1'b0}}};

    // clamp to the word range: {saturated, value}
    function automatic logic [W:0] clamp_w(input logic signed [SW-1:0] v);
        logic [W:0] r;
        if (v > SMAX) begin
            r = {1'b1, MAXW};
        end else if (v < SMIN) begin
            r = {1'b1, MINW};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    // operand words taken from the low bits of each field
    logic signed [W-1:0] in_ar, in_ai, in_br, in_bi;
    assign in_ar = signed'(q_item.a_re[W-1:0]);
    assign in_ai = signed'(q_item.a_im[W-1:0]);
    assign in_br = signed'(q_item.b_re[W-1:0]);
    assign in_bi = signed'(q_item.b_im[W-1:0]);

    // product stage registers
    logic                s1_valid_reg;
    cmd_t                s1_cmd_reg;
    logic                s1_div_reg;
    logic signed [W-1:0] s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;
    logic signed [PW-1:0] p_arbr_reg, p_aibi_reg, p_arbi_reg, p_aibr_reg;
    logic signed [PW-1:0] p_brbr_reg, p_bibi_reg;

    // output register
    logic                 out_valid_reg;
    logic [DATA_BITS-1:0] out_re_reg, out_im_reg;
    logic                 out_cmp_reg, out_dz_reg, out_sat_reg;

    // handshake between stages
    logic       out_free, s1_go, s1_load, div_path, out_load_s1, out_load_div;
    logic       div_start;
    div_stat_t  stat_re, stat_im;
    logic       div_idle, div_done;

    // result stage values
    logic signed [SW-1:0] mul_re, mul_im, num_re, num_im, v_re, v_im;
    logic [MW-1:0]        den, mag_re, mag_im;
    logic                 den_zero, neg_re, neg_im;
    logic [W:0]           c_re, c_im;
    logic [W-1:0]         r_re, r_im;
    logic                 r_cmp, r_dz, r_sat, eq;
    logic [W-1:0]         d_re, d_im;
    logic                 d_sat_re, d_sat_im;

    assign div_idle = stat_re.idle && stat_im.idle;
    assign div_done = stat_re.done && stat_im.done;

    // combine the products
    always_comb begin
        mul_re   = (SW'(p_arbr_reg) - SW'(p_aibi_reg)) >>> F;
        mul_im   = (SW'(p_arbi_reg) + SW'(p_aibr_reg)) >>> F;
        num_re   = SW'(p_arbr_reg) + SW'(p_aibi_reg);
        num_im   = SW'(p_aibr_reg) - SW'(p_arbi_reg);
        den      = MW'($unsigned(p_brbr_reg)) + MW'($unsigned(p_bibi_reg));
        den_zero = (den == '0);
        neg_re   = num_re[SW-1];
        neg_im   = num_im[SW-1];
        mag_re   = neg_re ? MW'(-num_re) : MW'(num_re);
        mag_im   = neg_im ? MW'(-num_im) : MW'(num_im);
        eq       = (s1_ar_reg == s1_br_reg) && (s1_ai_reg == s1_bi_reg);
    end

    // per-command result for everything but a divide by nonzero
    always_comb begin
        v_re  = '0;
        v_im  = '0;
        r_cmp = 1'b0;
        r_dz  = 1'b0;
        case (s1_cmd_reg)
            CMD_ADD: begin
                v_re = SW'(s1_ar_reg) + SW'(s1_br_reg);
                v_im = SW'(s1_ai_reg) + SW'(s1_bi_reg);
            end
            CMD_SUB: begin
                v_re = SW'(s1_ar_reg) - SW'(s1_br_reg);
                v_im = SW'(s1_ai_reg) - SW'(s1_bi_reg);
            end
            CMD_NEG: begin
                v_re = -SW'(s1_ar_reg);
                v_im = -SW'(s1_ai_reg);
            end
            CMD_MUL: begin
                v_re = mul_re;
                v_im = mul_im;
            end
            CMD_DIV: begin
                r_dz = den_zero;
            end
            CMD_SCALE: begin
                v_re = SW'(p_arbr_reg) >>> F;
                v_im = SW'(p_aibr_reg) >>> F;
            end
            CMD_EQ: begin
                r_cmp = eq;
            end
            CMD_NE: begin
                r_cmp = !eq;
            end
            default: begin
                r_cmp = 1'b0;
            end
        endcase
        c_re  = clamp_w(v_re);
        c_im  = clamp_w(v_im);
        r_re  = c_re[W-1:0];
        r_im  = c_im[W-1:0];
        r_sat = c_re[W] || c_im[W];
    end

    // stage control: the divider keeps results in order
    assign out_free     = !out_valid_reg || m_tready;
    assign div_path     = s1_div_reg && !den_zero;
    assign s1_go        = s1_valid_reg && div_idle && (div_path || out_free);
    assign div_start    = s1_go && div_path;
    assign out_load_s1  = s1_go && !div_path;
    assign out_load_div = div_done && out_free;
    assign s1_load      = q_valid && (!s1_valid_reg || s1_go);
    assign q_ready      = !s1_valid_reg || s1_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_load) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load_s1 || out_load_div) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // products, one multiplier each
    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_cmd_reg <= q_item.cmd;
            s1_div_reg <= q_item.is_div;
            s1_ar_reg  <= in_ar;
            s1_ai_reg  <= in_ai;
            s1_br_reg  <= in_br;
            s1_bi_reg  <= in_bi;
            p_arbr_reg <= in_ar * in_br;
            p_aibi_reg <= in_ai * in_bi;
            p_arbi_reg <= in_ar * in_bi;
            p_aibr_reg <= in_ai * in_br;
            p_brbr_reg <= in_br * in_br;
            p_bibi_reg <= in_bi * in_bi;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (out_load_div) begin
            out_re_reg  <= DATA_BITS'(signed'(d_re));
            out_im_reg  <= DATA_BITS'(signed'(d_im));
            out_cmp_reg <= 1'b0;
            out_dz_reg  <= 1'b0;
            out_sat_reg <= d_sat_re || d_sat_im;
        end else if (out_load_s1) begin
            out_re_reg  <= DATA_BITS'(signed'(r_re));
            out_im_reg  <= DATA_BITS'(signed'(r_im));
            out_cmp_reg <= r_cmp;
            out_dz_reg  <= r_dz;
            out_sat_reg <= r_sat;
        end
    end

    cau_div #(.W(W), .F(F)) u_div_re (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (div_start),
        .ack_i   (out_load_div),
        .neg_i   (neg_re),
        .mag_i   (mag_re),
        .den_i   (den),
        .stat_o  (stat_re),
        .res_o   (d_re),
        .sat_o   (d_sat_re)
    );

    cau_div #(.W(W), .F(F)) u_div_im (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (div_start),
        .ack_i   (out_load_div),
        .neg_i   (neg_im),
        .mag_i   (mag_im),
        .den_i   (den),
        .stat_o  (stat_im),
        .res_o   (d_im),
        .sat_o   (d_sat_im)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_im_reg, out_re_reg};
    assign m_tuser  = {out_sat_reg, out_dz_reg, out_cmp_reg};

`ifndef NO_ASSERTIONS
    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(out_load_s1 && out_load_div))
        else $error("output register written by both paths");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> !div_idle)
        else $error("divider did not start");

    a_div_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> ##(W + 2) div_done)
        else $error("divider result not ready in time");

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_cmd_reg))
        else $error("product stage lost a stalled item");
`endif

endmodule

[design/complex_arith_unit.sv]
// Complex arithmetic unit top level: front end queue and arithmetic back end.
// Complex arithmetic on signed fixed-point operands (WORD_BITS wide, FRAC_BITS
// fraction bits): add, subtract, negate, multiply, divide, real scale and
// compare, with results clamped to the word range. Every command but a divide
// by a nonzero divisor runs at one item per clock while the output is not
// stalled and no divide is running, passing through the input queue, the
// product stage and the output register. A divide with a nonzero divisor goes
// through a shift-subtract divider that yields one quotient bit per cycle and
// holds the back end until it is done; the two-entry input queue keeps
// accepting items meanwhile until it is full. Results leave in input order.
module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [4*DATA_BITS-1:0] s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [CMD_BITS-1:0]    s_tuser,   // command
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [2*DATA_BITS-1:0] m_tdata,   // res_re, res_im
    output logic [2:0]             m_tuser    // compare_true, div_zero, saturated
);

    logic      q_valid, q_ready;
    cau_item_t q_item;

    cau_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    cau_back #(.W(WORD_BITS), .F(FRAC_BITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
